// ----- rtl/ihex_pkg.sv -----
`default_nettype none
package ihex_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EOF  = 2'd1,
    KIND_STOP = 2'd2
  } kind_e;

  localparam logic RegWindowLow  = 1'b0;
  localparam logic RegWindowHigh = 1'b1;

  typedef struct packed {
    logic [31:0] low;
    logic [31:0] high;
  } window_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] addr;
    logic [7:0]  data;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/intel_hex_record_decoder_core.sv -----
// A character passes the input register, the parser and then the result register to out_valid_o.
// Takes one character per cycle unless a waiting result is held; in_stall_o follows out_stall_i when a result waits.
// Parser state and the input and result registers sit around it, so a data byte's address
// add and window compare form one combinational path between them.
// Reset: asynchronous, active low; clears parser state, window to [0, 0xFFFFFFFF).
`default_nettype none
module intel_hex_record_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      byte_address_o,
  output logic [7:0]       data_byte_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import ihex_pkg::*;

  window_t     window;
  result_t     res;
  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        adv;
  logic        out_valid_q;
  kind_e       kind_q;
  logic [31:0] addr_q;
  logic [7:0]  data_q;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) char_q <= char_in_i;
  end

  ihex_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .window_o    (window)
  );

  ihex_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .char_i   (char_q),
    .window_i (window),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      kind_q <= res.kind;
      addr_q <= res.addr;
      data_q <= res.data;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign byte_address_o = addr_q;
  assign data_byte_o    = data_q;

endmodule
`default_nettype wire

// ----- rtl/ihex_cfg.sv -----
`default_nettype none
module ihex_cfg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [31:0]     cfg_data_i,
  output ihex_pkg::window_t    window_o
);
  import ihex_pkg::*;

  logic [31:0] low_q, high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 32'h0000_0000;
      high_q <= 32'hFFFF_FFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegWindowLow:  low_q  <= cfg_data_i;
        RegWindowHigh: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign window_o.low  = low_q;
  assign window_o.high = high_q;

endmodule
`default_nettype wire

// ----- rtl/ihex_parse.sv -----
`default_nettype none
module ihex_parse (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         char_i,
  input  wire ihex_pkg::window_t  window_i,
  output ihex_pkg::result_t       res_o
);
  import ihex_pkg::*;

  localparam logic [7:0]  CharColon  = 8'h3A;
  localparam logic [7:0]  CharLf     = 8'h0A;
  localparam logic [15:0] TypeData   = 16'h3030;
  localparam logic [15:0] TypeEof    = 16'h3031;
  localparam logic [15:0] TypeExtSeg = 16'h3032;
  localparam logic [15:0] TypeExtLin = 16'h3034;
  localparam logic [9:0]  PosMax     = 10'd1023;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  logic [31:0] upper_q, upper_d;
  logic [15:0] line_q, line_d;
  logic [7:0]  count_q, count_d;
  logic [9:0]  pos_q, pos_d;
  logic [15:0] acc_q, acc_d;
  logic        bad_q, bad_d;
  logic [15:0] type_q, type_d;
  logic [7:0]  idx_q, idx_d;
  logic        skip_q, skip_d;
  logic        fin_q, fin_d;

  logic [4:0]  hd;
  logic [15:0] acc_take;
  logic        bad_take;
  logic [15:0] field_val;
  logic [15:0] type_next;
  logic [7:0]  idx_inc;
  logic [31:0] addr;
  logic        in_window;

  assign hd        = hex_digit(char_i);
  assign acc_take  = {acc_q[11:0], hd[4] ? hd[3:0] : 4'd0};
  assign bad_take  = bad_q | ~hd[4];
  assign field_val = bad_take ? 16'd0 : acc_take;
  assign type_next = {type_q[7:0], char_i};
  assign idx_inc   = idx_q + 8'd1;
  assign addr      = upper_q + {16'd0, line_q} + {24'd0, idx_q};
  assign in_window = (window_i.low <= addr) && (window_i.high > addr);

  always_comb begin
    upper_d = upper_q;
    line_d  = line_q;
    count_d = count_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    type_d  = type_q;
    idx_d   = idx_q;
    skip_d  = skip_q;
    fin_d   = fin_q;
    res_o   = '{valid: 1'b0, kind: KIND_DATA, addr: 32'd0, data: 8'd0};

    if (step_i && !fin_q) begin
      if (pos_q == 10'd0) begin
        if (char_i != CharColon) begin
          fin_d      = 1'b1;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_STOP;
        end else begin
          pos_d  = 10'd1;
          acc_d  = 16'd0;
          bad_d  = 1'b0;
          type_d = 16'd0;
          idx_d  = 8'd0;
          skip_d = 1'b0;
        end
      end else if (char_i == CharLf) begin
        pos_d  = 10'd0;
        skip_d = 1'b0;
      end else if (!skip_q) begin
        if (pos_q < PosMax) pos_d = pos_q + 10'd1;
        if (pos_q <= 10'd6) begin
          acc_d = acc_take;
          bad_d = bad_take;
          if (pos_q == 10'd2) begin
            count_d = field_val[7:0];
            acc_d   = 16'd0;
            bad_d   = 1'b0;
          end else if (pos_q == 10'd6) begin
            line_d = field_val;
            acc_d  = 16'd0;
            bad_d  = 1'b0;
          end
        end else if (pos_q <= 10'd8) begin
          type_d = type_next;
          if (pos_q == 10'd8) begin
            if (type_next == TypeData) begin
              if (count_q == 8'd0) skip_d = 1'b1;
            end else if (type_next == TypeEof) begin
              fin_d       = 1'b1;
              res_o.valid = 1'b1;
              res_o.kind  = KIND_EOF;
            end else if (type_next != TypeExtSeg && type_next != TypeExtLin) begin
              skip_d = 1'b1;
            end
          end
        end else begin
          acc_d = acc_take;
          bad_d = bad_take;
          if (type_q == TypeData) begin
            if (!pos_q[0]) begin
              acc_d = 16'd0;
              bad_d = 1'b0;
              idx_d = idx_inc;
              if (idx_inc >= count_q) skip_d = 1'b1;
              if (in_window) begin
                res_o.valid = 1'b1;
                res_o.kind  = KIND_DATA;
                res_o.addr  = addr;
                res_o.data  = field_val[7:0];
              end
            end
          end else if (pos_q == 10'd12) begin
            acc_d  = 16'd0;
            bad_d  = 1'b0;
            skip_d = 1'b1;
            if (type_q == TypeExtSeg) upper_d = {12'd0, field_val, 4'd0};
            else upper_d = {field_val, 16'd0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= 32'd0;
      line_q  <= 16'd0;
      count_q <= 8'd0;
      pos_q   <= 10'd0;
      acc_q   <= 16'd0;
      bad_q   <= 1'b0;
      type_q  <= 16'd0;
      idx_q   <= 8'd0;
      skip_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      upper_q <= upper_d;
      line_q  <= line_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
      type_q  <= type_d;
      idx_q   <= idx_d;
      skip_q  <= skip_d;
      fin_q   <= fin_d;
    end
  end

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q) else $error("finished flag dropped");

  a_no_res_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !res_o.valid) else $error("result after decoding stopped");

  a_data_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_DATA) |->
      (res_o.addr >= window_i.low && res_o.addr < window_i.high))
    else $error("data byte outside window");

  a_skip_clear_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == 10'd0) |-> !skip_q) else $error("line skip set at line start");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ihex_pkg::*;

  localparam logic [7:0]  CharColon   = 8'h3A;
  localparam logic [7:0]  CharLf      = 8'h0A;
  localparam logic [7:0]  CharCr      = 8'h0D;
  localparam logic [15:0] TypeData    = 16'h3030;
  localparam logic [15:0] TypeEof     = 16'h3031;
  localparam logic [15:0] TypeSegment = 16'h3032;
  localparam logic [15:0] TypeUnknown = 16'h3033;
  localparam logic [15:0] TypeLinear  = 16'h3034;
  localparam logic [9:0]  PosMax      = 10'd1023;
  localparam int          IdleLimit   = 5000;
  localparam int          PhaseChars  = 180;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [7:0]  data;
  } decoded_t;

  typedef enum {EndFull, EndCut, EndCorrupt, EndLong, EndBare} line_end_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] byte_address_o;
  logic [7:0]  data_byte_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = 32'd0;

  intel_hex_record_decoder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // decoder model state
  logic [31:0] win_low = 32'd0;
  logic [31:0] win_high = 32'hFFFF_FFFF;
  logic [31:0] rec_base = 32'd0;
  logic [15:0] rec_addr = 16'd0;
  logic [7:0]  rec_count = 8'd0;
  logic [9:0]  char_pos = 10'd0;
  logic [15:0] field_acc = 16'd0;
  logic        field_bad = 1'b0;
  logic [15:0] rec_type = 16'd0;
  logic [7:0]  byte_idx = 8'd0;
  logic        skip_line = 1'b0;
  logic        parse_done = 1'b0;

  logic [7:0] hex_text_q[$];
  logic [7:0] line_buf[$];
  decoded_t   decoded_q[$];
  int         chars_queued = 0;
  int         error_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_span = 0;
  int         stall_pct = 0;
  int         idle_cycles = 0;

  function automatic void shift_digit(input logic [7:0] c);
    logic [7:0] d;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else begin
      d = 8'd0;
      field_bad = 1'b1;
    end
    field_acc = {field_acc[11:0], d[3:0]};
  endfunction

  function automatic logic [15:0] field_value();
    logic [15:0] v;
    v = field_bad ? 16'd0 : field_acc;
    field_acc = 16'd0;
    field_bad = 1'b0;
    return v;
  endfunction

  function automatic bit decode_char(input logic [7:0] c, output decoded_t r);
    logic [9:0]  p;
    logic [15:0] fv;
    logic [31:0] a;
    r.kind = KIND_DATA;
    r.addr = 32'd0;
    r.data = 8'd0;
    if (parse_done) return 1'b0;
    if (char_pos == 10'd0) begin
      if (c != CharColon) begin
        parse_done = 1'b1;
        r.kind = KIND_STOP;
        return 1'b1;
      end
      char_pos = 10'd1;
      field_acc = 16'd0;
      field_bad = 1'b0;
      rec_type = 16'd0;
      byte_idx = 8'd0;
      skip_line = 1'b0;
      return 1'b0;
    end
    if (c == CharLf) begin
      char_pos = 10'd0;
      skip_line = 1'b0;
      return 1'b0;
    end
    if (skip_line) return 1'b0;
    p = char_pos;
    if (char_pos < PosMax) char_pos++;
    if (p == 10'd7 || p == 10'd8) begin
      rec_type = {rec_type[7:0], c};
      if (p == 10'd8) begin
        if (rec_type == TypeData) begin
          if (rec_count == 8'd0) skip_line = 1'b1;
        end else if (rec_type == TypeEof) begin
          parse_done = 1'b1;
          r.kind = KIND_EOF;
          return 1'b1;
        end else if (rec_type != TypeSegment && rec_type != TypeLinear) begin
          skip_line = 1'b1;
        end
      end
      return 1'b0;
    end
    shift_digit(c);
    if (p == 10'd2) begin
      fv = field_value();
      rec_count = fv[7:0];
    end else if (p == 10'd6) begin
      rec_addr = field_value();
    end else if (p >= 10'd9) begin
      if (rec_type == TypeData) begin
        if (!p[0]) begin
          fv = field_value();
          a = rec_base + {16'd0, rec_addr} + {24'd0, byte_idx};
          byte_idx++;
          if (byte_idx >= rec_count) skip_line = 1'b1;
          if (win_low <= a && win_high > a) begin
            r.addr = a;
            r.data = fv[7:0];
            return 1'b1;
          end
        end
      end else if (p == 10'd12) begin
        fv = field_value();
        rec_base = (rec_type == TypeSegment) ? {12'd0, fv, 4'd0} : {fv, 16'd0};
        skip_line = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (ch == CharLf);
    return ch;
  endfunction

  task automatic add_hex(input logic [31:0] val, input int digits);
    logic [3:0] n;
    for (int i = digits - 1; i >= 0; i--) begin
      n = val[4*i +: 4];
      if (n < 4'd10) line_buf.push_back("0" + n);
      else line_buf.push_back(($urandom_range(1) ? "a" : "A") + n - 8'd10);
    end
  endtask

  task automatic start_line(input logic [7:0] count, input logic [15:0] addr,
                            input logic [15:0] rtype);
    line_buf.delete();
    line_buf.push_back(CharColon);
    add_hex(32'(count), 2);
    add_hex(32'(addr), 4);
    line_buf.push_back(rtype[15:8]);
    line_buf.push_back(rtype[7:0]);
  endtask

  task automatic end_line(input line_end_e how);
    int keep;
    int at;
    case (how)
      EndCut: begin
        keep = $urandom_range(1, line_buf.size());
        while (line_buf.size() > keep) void'(line_buf.pop_back());
      end
      EndBare: ;
      default: begin
        if (how == EndCorrupt) begin
          at = $urandom_range(1, line_buf.size() - 1);
          line_buf[at] = junk_char();
        end
        add_hex($urandom_range(255), 2);
        if (how == EndLong) repeat ($urandom_range(1, 40)) line_buf.push_back(junk_char());
        if ($urandom_range(3) == 0) line_buf.push_back(CharCr);
      end
    endcase
    // end of file only comes with the final record
    if (line_buf.size() > 8 && {line_buf[7], line_buf[8]} == TypeEof) line_buf[8] = "5";
    foreach (line_buf[i]) hex_text_q.push_back(line_buf[i]);
    hex_text_q.push_back(CharLf);
    chars_queued += line_buf.size() + 1;
  endtask

  task automatic add_random_line();
    int pick;
    int n;
    logic [15:0] val;
    logic [15:0] rtype;
    line_end_e how;
    pick = $urandom_range(99);
    if (pick < 55) begin
      n = ($urandom_range(29) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
      start_line(8'(n), 16'($urandom), TypeData);
      repeat (n) add_hex($urandom_range(255), 2);
    end else if (pick < 70) begin
      rtype = $urandom_range(1) ? TypeLinear : TypeSegment;
      val = $urandom_range(1) ? win_low[31:16] + 16'($urandom_range(1)) : 16'($urandom);
      start_line(8'd2, 16'($urandom), rtype);
      add_hex(32'(val), 4);
    end else begin
      rtype = 16'($urandom);
      if ($urandom_range(1)) rtype[15:8] = "0";
      start_line(8'($urandom), 16'($urandom), rtype);
      repeat ($urandom_range(20)) line_buf.push_back(junk_char());
    end
    pick = $urandom_range(9);
    how = (pick < 6) ? EndFull : (pick < 8) ? EndCut : (pick == 8) ? EndCorrupt : EndLong;
    end_line(how);
  endtask

  task automatic write_window(input logic idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegWindowLow) win_low = val;
    else win_high = val;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (hex_text_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void compare_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      error_count++;
    end
  endfunction

  // sender: bursts of random length, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin : feed_chars
    decoded_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_in_i <= 8'd0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (decode_char(char_in_i, res)) decoded_q.push_back(res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (hex_text_q.size() != 0) begin
          in_valid_i <= 1'b1;
          char_in_i <= hex_text_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(4) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 20);
            gap_left <= $urandom_range(1) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall density changes from span to span
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span <= $urandom_range(10, 80);
        case ($urandom_range(4))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 25;
          3: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        stall_span <= stall_span - 1;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    decoded_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual kind %0d addr %h data %h",
                 $time, kind_o, byte_address_o, data_byte_o);
        error_count++;
      end else begin
        want = decoded_q.pop_front();
        compare_field("kind", 32'(want.kind), 32'(kind_o));
        compare_field("byte_address", want.addr, byte_address_o);
        compare_field("data_byte", 32'(want.data), 32'(data_byte_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int target;
    logic [31:0] lo;
    logic [7:0] ch;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_window(RegWindowLow, 32'd0);
          write_window(RegWindowHigh, 32'hFFFF_FFFF);
        end
        1: begin
          write_window(RegWindowLow, 32'hFFFF_FFFF);
          write_window(RegWindowHigh, 32'd0);
        end
        2: begin
          lo = $urandom;
          write_window(RegWindowLow, lo);
          write_window(RegWindowHigh, lo + $urandom_range(1, 32'h0002_0000));
        end
        3: begin
          lo = $urandom;
          write_window(RegWindowLow, lo);
          write_window(RegWindowHigh, lo);
        end
        4: begin
          write_window(RegWindowLow, 32'hFFFF_0000);
          write_window(RegWindowHigh, 32'hFFFF_FFFF);
        end
        default: begin
          write_window(RegWindowLow, 32'd0);
          write_window(RegWindowHigh, 32'h0001_8000);
        end
      endcase
      if (ph == 0) begin
        start_line(8'd4, 16'hFFFE, TypeData);
        add_hex(32'h00FF_A55A, 8);
        end_line(EndFull);
        start_line(8'd2, 16'h0000, TypeLinear);
        add_hex(32'h0000_FFFF, 4);
        end_line(EndFull);
        // address wraps past 2^32
        start_line(8'd3, 16'hFFFF, TypeData);
        add_hex(32'h0000_FF80, 6);
        end_line(EndFull);
        start_line(8'd2, 16'h0000, TypeSegment);
        add_hex(32'h0000_FFFF, 4);
        end_line(EndFull);
        start_line(8'd1, 16'hFFFF, TypeData);
        add_hex(32'h0000_0001, 2);
        end_line(EndFull);
        start_line(8'd0, 16'h0000, TypeData);
        end_line(EndFull);
        // bad digit in data, address and count
        start_line(8'd2, 16'h0020, TypeData);
        add_hex(32'h0000_0011, 2);
        line_buf.push_back("x");
        line_buf.push_back("7");
        end_line(EndFull);
        start_line(8'd1, 16'h0000, TypeData);
        line_buf[4] = "z";
        add_hex(32'h0000_007E, 2);
        end_line(EndFull);
        start_line(8'd1, 16'h0060, TypeData);
        line_buf[1] = "g";
        add_hex(32'h0000_0033, 2);
        end_line(EndFull);
        start_line(8'd1, 16'h0000, TypeUnknown);
        add_hex(32'h0000_0044, 2);
        end_line(EndFull);
        // short lines and an overlong line
        start_line(8'd4, 16'h0040, TypeData);
        add_hex(32'h0000_ABCD, 4);
        line_buf.push_back("E");
        end_line(EndBare);
        start_line(8'd2, 16'h0000, TypeLinear);
        add_hex(32'h0000_0012, 2);
        end_line(EndBare);
        start_line(8'd2, 16'h0050, TypeData);
        add_hex(32'h0000_0102, 4);
        end_line(EndLong);
      end
      start_line(8'd2, 16'h0000, TypeLinear);
      add_hex({16'd0, win_low[31:16]}, 4);
      end_line(EndFull);
      target = chars_queued + PhaseChars;
      while (chars_queued < target) add_random_line();
    end
    wait_idle();
    // either end-of-file record or a line without a colon, then trailing noise
    if ($urandom_range(1)) begin
      start_line(8'd0, 16'h0000, TypeEof);
      add_hex(32'h0000_00FF, 2);
    end else begin
      line_buf.delete();
      do ch = 8'($urandom_range(255)); while (ch == CharColon);
      line_buf.push_back(ch);
    end
    line_buf.push_back(CharLf);
    repeat (24) line_buf.push_back(8'($urandom_range(255)));
    foreach (line_buf[i]) hex_text_q.push_back(line_buf[i]);
    wait_idle();
    repeat (12) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
